FILE: src/fsos_pkg.sv
`default_nettype none

package fsos_pkg;

  localparam int unsigned OfferWordWidth = 32;
  localparam int unsigned PositionWidth  = 3;
  localparam int unsigned VoltageWidth   = 16;
  localparam int unsigned CurrentWidth   = 14;
  localparam int unsigned FieldWidth     = 10;

  // Power data object layout
  localparam int unsigned TypeMsb        = 31;
  localparam int unsigned TypeLsb        = 30;
  localparam int unsigned DualRoleBit    = 29;
  localparam int unsigned UsbCommsBit    = 26;
  localparam int unsigned VoltageLsb     = 10;
  localparam int unsigned CurrentLsb     = 0;

  localparam logic [1:0] PdoTypeFixed = 2'b00;

  localparam logic [VoltageWidth-1:0] MvPerStep    = 16'd50;
  localparam logic [CurrentWidth-1:0] MaPerStep    = 14'd10;
  localparam logic [VoltageWidth-1:0] LimitResetMv = 16'd20000;

  typedef struct packed {
    logic [OfferWordWidth-1:0] offer_word;
    logic                      last_offer;
  } offer_req_t;

  typedef struct packed {
    logic [PositionWidth-1:0] chosen_position;
    logic [VoltageWidth-1:0]  chosen_voltage_mv;
    logic [CurrentWidth-1:0]  chosen_current_ma;
    logic                     chosen_dual_role;
    logic                     chosen_usb_comms;
  } chosen_rsp_t;

endpackage

`default_nettype wire

FILE: src/fixed_supply_offer_selector_unit.sv
`default_nettype none

// Picks the best fixed-supply power data object from a source capabilities list fed one
// object per request, the last one marked. An object counts only if its type is fixed
// supply, its voltage is non-zero and not above the voltage limit register; among those,
// the highest voltage wins, then the higher current, then the earlier position. The last
// request yields one response with the 1-based position (0 and all-zero fields if nothing
// qualified) and the list state clears for the next list. Objects past MAX_OFFERS are
// ignored. One request is taken every cycle unless a last one waits on a full result; a
// response goes via the input register, then the result register, which lets the next
// list proceed while a response waits. Write the limit only while no list is in flight.
module fixed_supply_offer_selector_unit #(
  parameter int unsigned MAX_OFFERS = 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [15:0]                   cfg_wdata_i,
  input  wire                          req_valid_i,
  output logic                         req_ready_o,
  input  wire fsos_pkg::offer_req_t    req_i,
  output logic                         rsp_valid_o,
  input  wire                          rsp_ready_i,
  output fsos_pkg::chosen_rsp_t        rsp_o
);
  import fsos_pkg::*;

  localparam logic [PositionWidth-1:0] MaxCount = PositionWidth'(MAX_OFFERS);

  logic [VoltageWidth-1:0]  limit_q;

  offer_req_t               req_q;
  logic                     req_valid_q;

  logic [PositionWidth-1:0] offer_index_q, offer_index_d;
  logic [PositionWidth-1:0] best_index_q, best_index_d;
  logic [VoltageWidth-1:0]  best_voltage_q, best_voltage_d;
  logic [CurrentWidth-1:0]  best_current_q, best_current_d;
  logic [1:0]               best_flags_q, best_flags_d;

  chosen_rsp_t              rsp_q, rsp_d;
  logic                     rsp_valid_q, rsp_valid_d;

  logic                     advance;
  logic                     counted;
  logic [PositionWidth-1:0] position;
  logic [VoltageWidth-1:0]  volt;
  logic [CurrentWidth-1:0]  curr;
  logic                     qualifies;
  logic                     take;
  logic [PositionWidth-1:0] new_index;
  logic [VoltageWidth-1:0]  new_voltage;
  logic [CurrentWidth-1:0]  new_current;
  logic [1:0]               new_flags;

  // A held request moves on unless it is a last one and the result register is still full
  assign advance     = req_valid_q && (!req_q.last_offer || !rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitResetMv;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      req_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
  end

  // Evaluate the held object against the best so far
  always_comb begin
    counted  = offer_index_q < MaxCount;
    position = offer_index_q + PositionWidth'(1);
    volt     = VoltageWidth'(req_q.offer_word[VoltageLsb +: FieldWidth]) * MvPerStep;
    curr     = CurrentWidth'(req_q.offer_word[CurrentLsb +: FieldWidth]) * MaPerStep;
    qualifies = counted && (req_q.offer_word[TypeMsb:TypeLsb] == PdoTypeFixed) &&
                (volt != '0) && (volt <= limit_q);
    take = qualifies && ((best_index_q == '0) || (volt > best_voltage_q) ||
                         ((volt == best_voltage_q) && (curr > best_current_q)));

    new_index   = take ? position : best_index_q;
    new_voltage = take ? volt : best_voltage_q;
    new_current = take ? curr : best_current_q;
    new_flags   = take ? {req_q.offer_word[DualRoleBit], req_q.offer_word[UsbCommsBit]}
                       : best_flags_q;

    offer_index_d  = offer_index_q;
    best_index_d   = best_index_q;
    best_voltage_d = best_voltage_q;
    best_current_d = best_current_q;
    best_flags_d   = best_flags_q;
    rsp_d          = rsp_q;
    rsp_valid_d    = rsp_valid_q && !rsp_ready_i;

    if (advance) begin
      if (req_q.last_offer) begin
        rsp_d.chosen_position   = new_index;
        rsp_d.chosen_voltage_mv = new_voltage;
        rsp_d.chosen_current_ma = new_current;
        rsp_d.chosen_dual_role  = new_flags[1];
        rsp_d.chosen_usb_comms  = new_flags[0];
        rsp_valid_d    = 1'b1;
        // Drop the list state ready for the next list
        offer_index_d  = '0;
        best_index_d   = '0;
        best_voltage_d = '0;
        best_current_d = '0;
        best_flags_d   = '0;
      end else begin
        offer_index_d  = counted ? position : offer_index_q;
        best_index_d   = new_index;
        best_voltage_d = new_voltage;
        best_current_d = new_current;
        best_flags_d   = new_flags;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offer_index_q  <= '0;
      best_index_q   <= '0;
      best_voltage_q <= '0;
      best_current_q <= '0;
      best_flags_q   <= '0;
      rsp_valid_q    <= 1'b0;
    end else begin
      offer_index_q  <= offer_index_d;
      best_index_q   <= best_index_d;
      best_voltage_q <= best_voltage_d;
      best_current_q <= best_current_d;
      best_flags_q   <= best_flags_d;
      rsp_valid_q    <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offer_index_q <= MaxCount)
    else $error("offer count past maximum");

  a_best_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_index_q <= offer_index_q)
    else $error("best position beyond objects seen");

  a_empty_best_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_index_q == '0) |-> (best_voltage_q == '0 && best_current_q == '0 &&
                              best_flags_q == '0))
    else $error("best object state set with no position");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req_q.last_offer) |=> (rsp_valid_o && offer_index_q == '0 &&
                                       best_index_q == '0))
    else $error("last request did not yield a response and clear");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.chosen_position == '0) |->
      (rsp_o.chosen_voltage_mv == '0 && rsp_o.chosen_current_ma == '0))
    else $error("empty response carries non-zero fields");

endmodule

`default_nettype wire
